// ----- rtl/core/psp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psp_pkg
// Shared types and codes of the paged slot pool allocator.
// ----------------------------------------------------------------------------
package psp_pkg;

	localparam int ADDR_W = 32;
	localparam int CNT_W = 13;
	localparam int COUNT_MAX = 8191;

	typedef enum logic [1:0] {
		MODE_ALLOC = 2'd0,
		MODE_FREE  = 2'd1,
		MODE_QUERY = 2'd2,
		MODE_ALT   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NO_PAGES = 3'd1,
		ST_NOT_POOL = 3'd2,
		ST_NOT_SLOT = 3'd3,
		ST_NULL     = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		REG_BASE   = 2'd0,
		REG_HEADER = 2'd1,
		REG_STRIDE = 2'd2,
		REG_SPP    = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FILL,
		S_POP_RD,
		S_POP_WAIT,
		S_POP_ADDR,
		S_LOC_CHECK,
		S_LOC_DIV,
		S_LOC_SLOT,
		S_LOC_DIV2,
		S_LOC_END,
		S_PUSH,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [ADDR_W-1:0] payload_addr;
		logic [2:0]        status;
		logic [CNT_W-1:0]  free_slots;
	} result_t;

endpackage
`default_nettype wire

// ----- rtl/core/psp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psp_req_if / psp_rsp_if / psp_cfg_if
// Valid/ready channels of the slot pool allocator.
// ----------------------------------------------------------------------------
interface psp_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [31:0] address;
	modport source (output valid, mode, address, input ready);
	modport sink (input valid, mode, address, output ready);
endinterface

interface psp_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] payload_addr;
	logic [2:0]  status;
	logic [12:0] free_slots;
	modport source (output valid, payload_addr, status, free_slots, input ready);
	modport sink (input valid, payload_addr, status, free_slots, output ready);
endinterface

interface psp_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/psp_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psp_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module psp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

// ----- rtl/core/psp_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psp_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psp_div #(
	parameter int NW = 40,
	parameter int DW = 25
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               busy,
	output logic [NW-1:0]      quo,
	output logic [DW-1:0]      rem
);
	localparam int CW = $clog2(NW + 1);
	logic [CW-1:0]   cnt_q;
	logic [NW-1:0]   quo_q;
	logic [DW:0]     rem_q;
	logic [DW-1:0]   den_q;
	logic [DW:0]     trial;

	assign trial = {rem_q[DW-1:0], quo_q[NW-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(NW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (cnt_q != '0) begin
			if (!trial[DW]) begin
				rem_q <= trial;
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DW-1:0], quo_q[NW-1]};
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

	assign busy = cnt_q != '0;
	assign quo = quo_q;
	assign rem = rem_q[DW-1:0];
endmodule
`default_nettype wire

// ----- rtl/core/paged_slot_pool_allocator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// paged_slot_pool_allocator
// Fixed-size slot allocator with one LIFO free list across contiguous pages.
// ----------------------------------------------------------------------------
// channel  dir  words
// req      in   mode, address
// rsp      out  payload_addr, status, free_slots
// cfg      in   index, data
// Allocate pops the head through read, wait and address states; an empty list first
// gets a new page linked in the fill state. Free and query divide twice (page, then slot),
// and a valid free then pushes. Null or out-of-pool addresses go from check to done.
// Reset empties the list; the link RAM needs no clearing.
// req is taken only when idle and the result register is empty.
// ----------------------------------------------------------------------------
module paged_slot_pool_allocator #(
	parameter int MAX_PAGES = 16,
	parameter int MAX_SLOTS_PER_PAGE = 256,
	parameter int ADDR_BITS = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	psp_req_if.sink   req,
	psp_rsp_if.source rsp,
	psp_cfg_if.sink   cfg
);
	localparam int DEPTH = MAX_PAGES * MAX_SLOTS_PER_PAGE;
	localparam int LW = $clog2(DEPTH + 1);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW = $clog2(MAX_SLOTS_PER_PAGE + 1);
	localparam int PW = $clog2(MAX_PAGES + 1);
	localparam int PBW = 16 + SW;
	localparam int NW = 34 + PW + PBW;
	localparam int CW = psp_pkg::CNT_W;
	localparam int SLW = (MAX_SLOTS_PER_PAGE > 1) ? $clog2(MAX_SLOTS_PER_PAGE) : 0;
	localparam int RSH = LW + SLW;
	localparam int PRW = 2 * LW + 1;
	localparam logic [63:0] RCP = ((64'd1 << RSH) + 64'(MAX_SLOTS_PER_PAGE) - 64'd1)
		/ 64'(MAX_SLOTS_PER_PAGE);

	logic [31:0] base_q;
	logic [12:0] hdr_q;
	logic [15:0] stride_q;
	logic [8:0]  spp_q;

	psp_pkg::state_t state_q, state_d;
	logic [1:0]    mode_q;
	logic [31:0]   addr_q;
	logic [LW-1:0] head_q;
	logic          head_v_q;
	logic [CW-1:0] free_q;
	logic [PW-1:0] pages_q;
	logic [SW-1:0] fill_q;
	logic [LW-1:0] link_q;
	logic [NW-1:0] off_q;
	logic [PBW-1:0] pbytes_q;
	logic [2:0]    st_q;
	logic          out_v_q;
	psp_pkg::result_t out_q;

	// effective register values
	logic [15:0]   estride;
	logic [SW-1:0] espp;
	assign estride = (stride_q == '0) ? 16'd1 : stride_q;
	always_comb begin
		if (spp_q == '0) begin
			espp = SW'(1);
		end else if (32'(spp_q) > 32'(MAX_SLOTS_PER_PAGE)) begin
			espp = SW'(MAX_SLOTS_PER_PAGE);
		end else begin
			espp = SW'(spp_q);
		end
	end

	// link RAM
	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [LW-1:0] ram_wdata, ram_rdata;
	psp_ram #(.WIDTH(LW), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	// shared divider
	logic          div_start, div_busy;
	logic [NW-1:0] div_num, div_quo;
	logic [PBW-1:0] div_den, div_rem;
	psp_div #(.NW(NW), .DW(PBW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.busy(div_busy), .quo(div_quo), .rem(div_rem)
	);

	logic [LW-1:0] fill_link, pop_next;
	assign fill_link = LW'(32'(pages_q) * MAX_SLOTS_PER_PAGE + 32'(fill_q));
	assign pop_next = ram_rdata;

	logic [NW-1:0] span;
	logic [NW-1:0] in_off;
	assign span = NW'(pbytes_q) * NW'(pages_q);

	assign req.ready = (state_q == psp_pkg::S_IDLE) && !out_v_q;
	assign cfg.ready = 1'b1;
	assign rsp.valid = out_v_q;
	assign rsp.payload_addr = out_q.payload_addr;
	assign rsp.status = out_q.status;
	assign rsp.free_slots = out_q.free_slots;

	logic [63:0] alloc_addr;
	logic [LW-1:0] pg_of_head;
	logic [LW-1:0] sl_of_head;
	logic [PRW-1:0] pg_prod;
	assign pg_prod = PRW'(head_q) * PRW'(RCP);
	assign pg_of_head = LW'(pg_prod >> RSH);
	assign sl_of_head = head_q - pg_of_head * LW'(MAX_SLOTS_PER_PAGE);
	assign alloc_addr = 64'(base_q) + 64'(off_q) + 64'(sl_of_head) * 64'(estride)
		+ 64'(hdr_q);
	assign in_off = NW'(div_rem);

	always_comb begin
		state_d = state_q;
		ram_we = 1'b0;
		ram_addr = head_q[AW-1:0];
		ram_wdata = head_v_q ? head_q : LW'(DEPTH);
		div_start = 1'b0;
		div_num = off_q;
		div_den = pbytes_q;
		unique case (state_q)
			psp_pkg::S_IDLE: begin
				if (req.valid && req.ready) begin
					if (req.mode == psp_pkg::MODE_ALLOC) begin
						state_d = psp_pkg::S_POP_RD;
					end else begin
						state_d = psp_pkg::S_LOC_CHECK;
					end
				end
			end
			psp_pkg::S_FILL: begin
				ram_we = 1'b1;
				ram_addr = fill_link[AW-1:0];
				if (fill_q == espp - 1'b1) begin
					state_d = psp_pkg::S_POP_RD;
				end
			end
			psp_pkg::S_POP_RD: begin
				if (free_q == '0 || !head_v_q) begin
					if (32'(pages_q) >= MAX_PAGES) begin
						state_d = psp_pkg::S_DONE;
					end else begin
						state_d = psp_pkg::S_FILL;
					end
				end else begin
					state_d = psp_pkg::S_POP_WAIT;
				end
			end
			psp_pkg::S_POP_WAIT: state_d = psp_pkg::S_POP_ADDR;
			psp_pkg::S_POP_ADDR: state_d = psp_pkg::S_DONE;
			psp_pkg::S_LOC_CHECK: begin
				if (addr_q == '0 || addr_q < base_q
				    || NW'(addr_q - base_q) >= span) begin
					state_d = psp_pkg::S_DONE;
				end else begin
					div_start = 1'b1;
					div_num = NW'(addr_q - base_q);
					state_d = psp_pkg::S_LOC_DIV;
				end
			end
			psp_pkg::S_LOC_DIV: begin
				if (!div_busy) begin
					state_d = psp_pkg::S_LOC_SLOT;
				end
			end
			psp_pkg::S_LOC_SLOT: begin
				if (in_off < NW'(hdr_q)) begin
					state_d = psp_pkg::S_DONE;
				end else begin
					div_start = 1'b1;
					div_num = in_off - NW'(hdr_q);
					div_den = PBW'(estride);
					state_d = psp_pkg::S_LOC_DIV2;
				end
			end
			psp_pkg::S_LOC_DIV2: begin
				if (!div_busy) begin
					state_d = psp_pkg::S_LOC_END;
				end
			end
			psp_pkg::S_LOC_END: begin
				if (div_rem != '0 || div_quo >= NW'(espp)
				    || off_q >= NW'(MAX_PAGES) || mode_q != psp_pkg::MODE_FREE) begin
					state_d = psp_pkg::S_DONE;
				end else begin
					state_d = psp_pkg::S_PUSH;
				end
			end
			psp_pkg::S_PUSH: begin
				ram_we = 1'b1;
				ram_addr = link_q[AW-1:0];
				state_d = psp_pkg::S_DONE;
			end
			psp_pkg::S_DONE: state_d = psp_pkg::S_IDLE;
			default: state_d = psp_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psp_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			hdr_q <= 13'd4;
			stride_q <= 16'd16;
			spp_q <= 9'd256;
			head_q <= '0;
			head_v_q <= 1'b0;
			free_q <= '0;
			pages_q <= '0;
			fill_q <= '0;
			link_q <= '0;
			off_q <= '0;
			pbytes_q <= '0;
			out_v_q <= 1'b0;
			st_q <= psp_pkg::ST_OK;
		end else begin
			if (cfg.valid && cfg.ready) begin
				unique case (psp_pkg::reg_idx_t'(cfg.index))
					psp_pkg::REG_BASE:   base_q <= cfg.data;
					psp_pkg::REG_HEADER: hdr_q <= cfg.data[12:0];
					psp_pkg::REG_STRIDE: stride_q <= cfg.data[15:0];
					psp_pkg::REG_SPP:    spp_q <= cfg.data[8:0];
					default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				psp_pkg::S_IDLE: begin
					st_q <= psp_pkg::ST_OK;
					fill_q <= '0;
					pbytes_q <= PBW'(32'(estride) * 32'(espp));
				end
				psp_pkg::S_FILL: begin
					head_q <= fill_link;
					head_v_q <= 1'b1;
					fill_q <= fill_q + 1'b1;
					if (fill_q == espp - 1'b1) begin
						pages_q <= pages_q + 1'b1;
						free_q <= (32'(free_q) + 32'(espp) > psp_pkg::COUNT_MAX)
							? CW'(psp_pkg::COUNT_MAX) : CW'(32'(free_q) + 32'(espp));
					end
				end
				psp_pkg::S_POP_RD: begin
					if ((free_q == '0 || !head_v_q) && 32'(pages_q) >= MAX_PAGES) begin
						st_q <= psp_pkg::ST_NO_PAGES;
					end
					off_q <= NW'(pbytes_q) * NW'(pg_of_head);
				end
				psp_pkg::S_POP_WAIT: ;
				psp_pkg::S_POP_ADDR: begin
					if (32'(pop_next) >= DEPTH) begin
						head_v_q <= 1'b0;
					end else begin
						head_q <= pop_next;
					end
					if (free_q != '0) begin
						free_q <= free_q - 1'b1;
					end
					off_q <= NW'(alloc_addr & ((64'd1 << ADDR_BITS) - 64'd1));
				end
				psp_pkg::S_LOC_CHECK: begin
					if (addr_q == '0) begin
						st_q <= psp_pkg::ST_NULL;
					end else if (addr_q < base_q || NW'(addr_q - base_q) >= span) begin
						st_q <= psp_pkg::ST_NOT_POOL;
					end
				end
				psp_pkg::S_LOC_SLOT: begin
					off_q <= div_quo;
					if (in_off < NW'(hdr_q)) begin
						st_q <= psp_pkg::ST_NOT_SLOT;
					end
				end
				psp_pkg::S_LOC_END: begin
					link_q <= LW'(off_q * NW'(MAX_SLOTS_PER_PAGE) + div_quo);
					if (div_rem != '0 || div_quo >= NW'(espp) || off_q >= NW'(MAX_PAGES)) begin
						st_q <= psp_pkg::ST_NOT_SLOT;
					end
				end
				psp_pkg::S_PUSH: begin
					head_q <= link_q;
					head_v_q <= 1'b1;
					if (32'(free_q) < psp_pkg::COUNT_MAX) begin
						free_q <= free_q + 1'b1;
					end
				end
				psp_pkg::S_DONE: begin
					out_v_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			mode_q <= req.mode;
			addr_q <= req.address;
		end
		if (state_q == psp_pkg::S_DONE) begin
			out_q.payload_addr <= (mode_q == psp_pkg::MODE_ALLOC && st_q == psp_pkg::ST_OK)
				? off_q[31:0] : 32'd0;
			out_q.status <= st_q;
			out_q.free_slots <= free_q;
		end
	end
endmodule
`default_nettype wire
